// ----- rtl/front_middle_back_queue_top_macros.svh -----
// ----------------------------------------------------------------------------
// Front/middle/back queue assertion macros
// Shared concurrent assertion forms for the queue RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef FRONT_MIDDLE_BACK_QUEUE_TOP_MACROS_SVH
`define FRONT_MIDDLE_BACK_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked while out of reset.
`define FMBQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue assertion failed");

// Next-cycle implication, checked while out of reset.
`define FMBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue assertion failed");

`else

`define FMBQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FMBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/fmbq_pkg.sv -----
// ----------------------------------------------------------------------------
// Front/middle/back queue package
// Sizes, request and status codes, cell control types and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fmbq_pkg;

  // Queue sizing.
  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int REQ_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int EXT_W      = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_MID   = 3'd1,
    REQ_PUSH_BACK  = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_MID    = 3'd4,
    REQ_POP_BACK   = 3'd5
  } req_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Request sequencer states.
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // What the cell row does for one request.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_DELETE
  } act_t;

  // Per-cell operation.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  // Control handed from the sequencer to the cell row.
  typedef struct packed {
    logic                  fire;
    act_t                  act;
    logic [IDX_W-1:0]      pos;
    logic [CNT_W-1:0]      count;
    logic [DATA_WIDTH-1:0] value;
  } chain_ctrl_t;

  // Sign-extend a stored entry and keep the low result bits.
  function automatic logic [VALUE_W-1:0] widen(input logic [DATA_WIDTH-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'($signed(v));
    return ext[VALUE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fmbq_if.sv -----
// ----------------------------------------------------------------------------
// Front/middle/back queue channels
// Valid/ready request and result channels with source and sink views.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel.
interface fmbq_in_if;
  import fmbq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [VALUE_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

// Result channel.
interface fmbq_out_if;
  import fmbq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] pop_value;
  logic [STATUS_W-1:0]       status;
  logic [CNT_W-1:0]          entry_count;

  modport source (output valid, output pop_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/fmbq_cell.sv -----
// ----------------------------------------------------------------------------
// Queue cell
// One queue slot: holds, loads a new value or takes a neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module fmbq_cell (
  input  wire logic                           clk,
  input  wire fmbq_pkg::cell_op_t             op,
  input  wire logic [fmbq_pkg::DATA_WIDTH-1:0] load_data,
  input  wire logic [fmbq_pkg::DATA_WIDTH-1:0] left_data,
  input  wire logic [fmbq_pkg::DATA_WIDTH-1:0] right_data,
  output logic      [fmbq_pkg::DATA_WIDTH-1:0] q
);
  import fmbq_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // Select the next slot value.
  always_comb begin
    case (op)
      CELL_LOAD:       data_nxt = load_data;
      CELL_FROM_LEFT:  data_nxt = left_data;
      CELL_FROM_RIGHT: data_nxt = right_data;
      default:         data_nxt = data_r;
    endcase
  end

  // Slot storage carries payload only, so it has no reset.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

`default_nettype wire

// ----- rtl/fmbq_chain.sv -----
// ----------------------------------------------------------------------------
// Queue cell row
// Row of cells in queue order; inserts shift the tail right, deletes left.
// ----------------------------------------------------------------------------
`default_nettype none

module fmbq_chain (
  input  wire logic                            clk,
  input  wire fmbq_pkg::chain_ctrl_t           ctrl,
  output logic      [fmbq_pkg::DATA_WIDTH-1:0] rd_data
);
  import fmbq_pkg::*;

  logic [DATA_WIDTH-1:0] cell_q   [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_sel [CAPACITY];
  cell_op_t              cell_op  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    // Row ends feed back their own value.
    if (i == 0) begin : g_first
      assign left_d = cell_q[i];
    end else begin : g_left
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_right
      assign right_d = cell_q[i+1];
    end

    // Decide this cell's move from the request position and the fill level.
    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (ctrl.fire) begin
        case (ctrl.act)
          ACT_INSERT: begin
            if (IDX_W'(i) == ctrl.pos) begin
              cell_op[i] = CELL_LOAD;
            end else if (IDX_W'(i) > ctrl.pos && CNT_W'(i) <= ctrl.count) begin
              cell_op[i] = CELL_FROM_LEFT;
            end
          end
          ACT_DELETE: begin
            if (IDX_W'(i) >= ctrl.pos && CNT_W'(i + 1) < ctrl.count) begin
              cell_op[i] = CELL_FROM_RIGHT;
            end
          end
          default: cell_op[i] = CELL_HOLD;
        endcase
      end
    end

    // Drive this cell's value onto the read bus when it is addressed.
    assign cell_sel[i] = (IDX_W'(i) == ctrl.pos) ? cell_q[i] : '0;

    fmbq_cell u_cell (
      .clk        (clk),
      .op         (cell_op[i]),
      .load_data  (ctrl.value),
      .left_data  (left_d),
      .right_data (right_d),
      .q          (cell_q[i])
    );
  end

  // Read bus: OR of the masked cell values.
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_data = rd_data | cell_sel[k];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/front_middle_back_queue_top.sv -----
// ----------------------------------------------------------------------------
// Front/middle/back queue
// Queue with push and pop at the front, middle and back, held in a cell row.
// ----------------------------------------------------------------------------
// Each request is accepted and decoded against the fill level in idle,
// then in the execute state the cell row shifts to insert or remove the
// entry and the result is loaded, once the output register is free. No
// new request is taken until that row update is done. A finished result
// waits in the output register while the next request is accepted.
// A push to a full queue is dropped and flagged, a pop from an empty queue
// returns -1 with an empty status, and request codes 6 and 7 leave the queue
// alone. The cells need no clearing after reset; only filled cells are read.
`default_nettype none

module front_middle_back_queue_top (
  input  wire logic clk,
  input  wire logic rst_n,
  fmbq_in_if.sink   in_if,
  fmbq_out_if.source out_if
);
  import fmbq_pkg::*;

  `include "front_middle_back_queue_top_macros.svh"

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r;
  logic                  out_valid_r;
  act_t                  act_r, act_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  status_t               stat_r, stat_nxt;
  logic [DATA_WIDTH-1:0] value_r;
  logic [VALUE_W-1:0]    pop_value_r;
  status_t               out_status_r;
  logic                  accept;
  logic                  exec_fire;
  logic                  in_ready;
  logic                  full;
  logic                  empty;
  logic [CNT_W-1:0]      cnt_m1;
  logic [DATA_WIDTH-1:0] rd_data;
  chain_ctrl_t           ctrl;

  // Sequencer: accept in idle, update the row once the output slot is free.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    exec_fire = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_if.ready) begin
          exec_fire = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign accept      = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  // Decode the request against the fill level.
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);
  assign cnt_m1 = count_r - CNT_W'(1);

  always_comb begin
    act_nxt  = ACT_NONE;
    pos_nxt  = '0;
    stat_nxt = STAT_OK;
    case (req_t'(in_if.req_type))
      REQ_PUSH_FRONT, REQ_PUSH_MID, REQ_PUSH_BACK: begin
        if (full) begin
          stat_nxt = STAT_FULL;
        end else begin
          act_nxt = ACT_INSERT;
          case (req_t'(in_if.req_type))
            REQ_PUSH_MID:  pos_nxt = IDX_W'(count_r >> 1);
            REQ_PUSH_BACK: pos_nxt = IDX_W'(count_r);
            default:       pos_nxt = '0;
          endcase
        end
      end
      REQ_POP_FRONT, REQ_POP_MID, REQ_POP_BACK: begin
        if (empty) begin
          stat_nxt = STAT_EMPTY;
        end else begin
          act_nxt = ACT_DELETE;
          case (req_t'(in_if.req_type))
            REQ_POP_MID:  pos_nxt = IDX_W'(cnt_m1 >> 1);
            REQ_POP_BACK: pos_nxt = IDX_W'(cnt_m1);
            default:      pos_nxt = '0;
          endcase
        end
      end
      default: begin
        act_nxt  = ACT_NONE;
        stat_nxt = STAT_OK;
      end
    endcase
  end

  // Decoded request held for the row update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ACT_NONE;
    end else if (accept) begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r   <= pos_nxt;
      stat_r  <= stat_nxt;
      value_r <= DATA_WIDTH'($unsigned(in_if.push_value));
    end
  end

  // Cell row.
  assign ctrl.fire  = exec_fire;
  assign ctrl.act   = act_r;
  assign ctrl.pos   = pos_r;
  assign ctrl.count = count_r;
  assign ctrl.value = value_r;

  fmbq_chain u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .rd_data (rd_data)
  );

  // Fill level follows each row update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (exec_fire) begin
      if (act_r == ACT_INSERT) begin
        count_r <= count_r + CNT_W'(1);
      end else if (act_r == ACT_DELETE) begin
        count_r <= cnt_m1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_status_r <= stat_r;
      if (act_r == ACT_DELETE) begin
        pop_value_r <= widen(rd_data);
      end else if (stat_r == STAT_EMPTY) begin
        pop_value_r <= '1;
      end else begin
        pop_value_r <= '0;
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.pop_value   = pop_value_r;
  assign out_if.status      = out_status_r;
  assign out_if.entry_count = count_r;

  // Checks.
  `FMBQ_ASSERT_IMPL(a_count_in_range, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `FMBQ_ASSERT_IMPL(a_busy_not_ready, clk, rst_n, state_r == S_EXEC, !in_ready)
  `FMBQ_ASSERT_NEXT(a_count_idle_stable, clk, rst_n, state_r == S_IDLE, $stable(count_r))
  `FMBQ_ASSERT_IMPL(a_full_flag, clk, rst_n, out_valid_r && out_status_r == STAT_FULL, full)
  `FMBQ_ASSERT_IMPL(a_empty_value, clk, rst_n, out_valid_r && out_status_r == STAT_EMPTY, pop_value_r == '1 && empty)

endmodule

`default_nettype wire

// ----- verif/tb_front_middle_back_queue_top.sv -----
// ----------------------------------------------------------------------------
// Front/middle/back queue testbench
// Drives push and pop requests at all three positions, mirrors the queue
// contents as a flat ordered list, and compares every result item with the
// mirror's prediction. Covers empty pops, full pushes, ignored codes,
// value extremes, long output stalls and a long biased random mix.
// ----------------------------------------------------------------------------
module tb_front_middle_back_queue_top;
  import fmbq_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 16;

  // Request codes that the block ignores.
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  localparam logic [REQ_W-1:0] PUSH_CODES[3] = '{REQ_PUSH_FRONT, REQ_PUSH_MID, REQ_PUSH_BACK};
  localparam logic [REQ_W-1:0] POP_CODES[3]  = '{REQ_POP_FRONT, REQ_POP_MID, REQ_POP_BACK};

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  // One expected result item.
  typedef struct {
    logic signed [VALUE_W-1:0] pop_value;
    status_t                   status;
    logic [CNT_W-1:0]          entry_count;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  fmbq_in_if  in_ch ();
  fmbq_out_if out_ch ();

  front_middle_back_queue_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  // Queue contents in order, front first.
  logic [DATA_WIDTH-1:0] queue_mirror[$];
  reply_t                expected_replies[$];

  int requests_sent   = 0;
  int mismatch_count  = 0;
  int cycle_count     = 0;
  int burst_left      = 0;
  bit steady_sender   = 1'b0;
  int hold_request    = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one request to the mirror and return the result it should give.
  function automatic reply_t predict_reply(input logic [REQ_W-1:0] code,
                                           input logic signed [VALUE_W-1:0] value);
    reply_t                r;
    int                    n;
    int                    idx;
    logic [DATA_WIDTH-1:0] stored;
    logic [DATA_WIDTH-1:0] taken;
    r.pop_value = '0;
    r.status    = STAT_OK;
    n           = queue_mirror.size();
    stored      = DATA_WIDTH'($unsigned(value));
    taken       = '0;
    case (code)
      REQ_PUSH_FRONT, REQ_PUSH_MID, REQ_PUSH_BACK: begin
        if (n >= CAPACITY) begin
          r.status = STAT_FULL;
        end else if (code == REQ_PUSH_FRONT) begin
          queue_mirror.insert(0, stored);
        end else if (code == REQ_PUSH_BACK || n == 0) begin
          queue_mirror.insert(n, stored);
        end else begin
          // A middle push lands right after the front half.
          queue_mirror.insert(n / 2, stored);
        end
      end
      REQ_POP_FRONT, REQ_POP_MID, REQ_POP_BACK: begin
        if (n == 0) begin
          r.pop_value = -1;
          r.status    = STAT_EMPTY;
        end else begin
          if (code == REQ_POP_FRONT) begin
            idx = 0;
          end else if (code == REQ_POP_BACK) begin
            idx = n - 1;
          end else begin
            // Last of the front half on even counts, first of the back half on odd.
            idx = (n - 1) / 2;
          end
          taken = queue_mirror[idx];
          queue_mirror.delete(idx);
          r.pop_value = VALUE_W'($signed(taken));
        end
      end
      default: begin
      end
    endcase
    r.entry_count = CNT_W'(queue_mirror.size());
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 15))
      0:       return VALUE_MIN;
      1:       return VALUE_MAX;
      2:       return '0;
      3:       return -1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Offer one item and record its prediction once it is accepted.
  task automatic issue_request(input logic [REQ_W-1:0] code,
                               input logic signed [VALUE_W-1:0] value);
    int gap;
    if (!steady_sender && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= code;
    in_ch.push_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    expected_replies.insert(expected_replies.size(), predict_reply(code, value));
    if (code <= REQ_POP_BACK) requests_sent++;
  endtask

  task automatic issue_push();
    issue_request(PUSH_CODES[$urandom_range(0, 2)], random_value());
  endtask

  task automatic issue_pop();
    issue_request(POP_CODES[$urandom_range(0, 2)], random_value());
  endtask

  // Empty pops of every kind, then the single-entry cases.
  task automatic test_empty_and_single();
    issue_request(REQ_POP_FRONT, 32'sd5);
    issue_request(REQ_POP_MID, VALUE_MAX);
    issue_request(REQ_POP_BACK, VALUE_MIN);
    issue_request(REQ_PUSH_BACK, 32'sd11);
    issue_request(REQ_POP_MID, '0);
    issue_request(REQ_PUSH_MID, 32'sd12);
    issue_request(REQ_POP_FRONT, '0);
    issue_request(REQ_PUSH_FRONT, 32'sd13);
    issue_request(REQ_POP_BACK, '0);
  endtask

  // Extremes of the value field through every push and pop.
  task automatic test_value_extremes();
    issue_request(REQ_PUSH_FRONT, VALUE_MIN);
    issue_request(REQ_PUSH_BACK, VALUE_MAX);
    issue_request(REQ_PUSH_MID, -1);
    issue_request(REQ_PUSH_MID, '0);
    issue_request(REQ_PUSH_FRONT, 32'sh5555_5555);
    issue_request(REQ_POP_MID, '0);
    issue_request(REQ_POP_MID, '0);
    issue_request(REQ_POP_FRONT, '0);
    issue_request(REQ_POP_BACK, '0);
    issue_request(REQ_POP_BACK, '0);
  endtask

  // Codes 6 and 7 must leave the queue alone.
  task automatic test_unused_codes();
    issue_request(REQ_PUSH_BACK, 32'sd21);
    issue_request(REQ_UNUSED_LO, VALUE_MAX);
    issue_request(REQ_UNUSED_HI, -1);
    issue_request(REQ_POP_FRONT, '0);
    issue_request(REQ_UNUSED_HI, '0);
  endtask

  // Fill to capacity, push past it, then drain and pop past empty.
  task automatic test_fill_to_capacity();
    while (queue_mirror.size() < CAPACITY) issue_push();
    foreach (PUSH_CODES[i]) issue_request(PUSH_CODES[i], random_value());
    issue_push();
    while (queue_mirror.size() > 0) issue_pop();
    foreach (POP_CODES[i]) issue_request(POP_CODES[i], random_value());
  endtask

  // The receiver stops for a long stretch while items keep coming.
  task automatic test_output_stall();
    steady_sender = 1'b1;
    hold_request  = 150;
    repeat (30) begin
      if ($urandom_range(0, 2) != 0) issue_push();
      else issue_pop();
    end
    steady_sender = 1'b0;
  endtask

  // Phases biased toward growth, balance or shrinkage, so the queue swings
  // between empty and full many times.
  task automatic test_random_mix();
    int phase_len;
    int push_pct;
    while (requests_sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      steady_sender = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        if ($urandom_range(0, 49) == 0) begin
          issue_request($urandom_range(0, 1) ? REQ_UNUSED_HI : REQ_UNUSED_LO, random_value());
        end else if ($urandom_range(0, 99) < push_pct) begin
          issue_push();
        end else begin
          issue_pop();
        end
      end
    end
    steady_sender = 1'b0;
  endtask

  // Stimulus sequence and end of run.
  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_PUSH_FRONT;
    in_ch.push_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_single();
    test_value_extremes();
    test_unused_codes();
    test_fill_to_capacity();
    test_output_stall();
    test_random_mix();

    in_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_front_middle_back_queue_top passed");
    end else begin
      $display("tb_front_middle_back_queue_top failed");
    end
    $finish;
  end

  // Receiver: a rotating stall pattern that changes now and then, plus a
  // long hold-off on request.
  initial begin
    int          hold_left;
    int          mode_age;
    logic [15:0] pattern;
    hold_left = 0;
    mode_age  = 0;
    pattern   = '1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (mode_age == 0) begin
        mode_age = $urandom_range(40, 160);
        case ($urandom_range(0, 2))
          0:       pattern = '1;
          1:       pattern = 16'($urandom) | 16'h0001;
          default: pattern = ~(16'd1 << $urandom_range(0, 15));
        endcase
      end
      mode_age--;
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= pattern[0];
        pattern = {pattern[0], pattern[15:1]};
      end
    end
  end

  // Compare each accepted result item with the oldest prediction.
  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_replies.size() == 0) begin
        $error("result item with no request outstanding: pop_value %0d status %0d count %0d",
               out_ch.pop_value, out_ch.status, out_ch.entry_count);
        mismatch_count++;
      end else begin
        exp_r = expected_replies[0];
        expected_replies.delete(0);
        if (out_ch.pop_value !== exp_r.pop_value) begin
          $error("pop_value: expected %0d, got %0d", exp_r.pop_value, out_ch.pop_value);
          mismatch_count++;
        end
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_ch.status);
          mismatch_count++;
        end
        if (out_ch.entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count, out_ch.entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_front_middle_back_queue_top failed");
      $finish;
    end
  end

endmodule
